// ----- src/hba_pkg.sv -----
// ----------------------------------------------------------------------------
// hba_pkg
// Shared types and codes for the heap block allocator.
// ----------------------------------------------------------------------------
package hba_pkg;

    // granule size is a power of two so byte offsets split by shift and mask
    localparam int GRANULE_BYTES = 16;
    localparam int GRAN_SHIFT    = 4;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_RELEASED  = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    localparam logic [1:0] CFG_FIT_STRATEGY = 2'd0;
    localparam logic [1:0] CFG_HEAP_BASE    = 2'd1;
    localparam logic [1:0] CFG_HEAP_UNITS   = 2'd2;

    typedef struct packed {
        logic        func;
        logic [16:0] req_bytes;
        logic [31:0] release_addr;
    } t_req;

    typedef struct packed {
        logic [31:0] block_addr;
        logic [1:0]  status;
    } t_rsp;

    // configuration as seen by the sequencer
    typedef struct packed {
        logic        fit_strategy;
        logic [31:0] heap_base;
        logic [12:0] heap_units;
        logic        form;
    } t_cfg;

endpackage

// ----- src/heap_block_allocator.sv -----
// ----------------------------------------------------------------------------
// heap_block_allocator
// First-fit / last-fit heap allocator with in-band boundary-tag headers.
//
//   channel  direction  handshake             payload
//   in       input      i_in_valid/o_in_stall   i_in_data   (t_req)
//   out      output     o_out_valid/i_out_stall o_out_data  (t_rsp)
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One item at a time. Each request but a release of address zero first
// passes through the registered granule scaler. Allocate then reads one
// header per cycle along the block chain; release merges free neighbours.
// After reset and after each heap_units write the header store is swept
// while the input is stalled. The result register lets the next request
// be taken while a result waits on i_out_stall.
// ----------------------------------------------------------------------------
module heap_block_allocator #(
    parameter int HEADER_UNITS  = 1,
    parameter int HEAP_UNITS    = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hba_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output hba_pkg::t_rsp o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import hba_pkg::*;

    localparam int IW = $clog2(HEAP_UNITS);
    localparam int LW = $clog2(HEAP_UNITS + 1);
    localparam int HW = 2 * LW + 3;

    logic          r_fit_strategy;
    logic [31:0]   r_heap_base;
    logic [12:0]   r_heap_units;
    logic          r_form;
    t_cfg          cfg;
    logic          div_start;
    logic [31:0]   div_dividend;
    logic          div_done;
    logic [31:0]   div_quot;
    logic [31:0]   div_rem;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [HW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [HW-1:0] mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_strategy <= 1'b0;
            r_heap_base    <= '0;
            r_heap_units   <= 13'd4096;
            r_form         <= 1'b0;
        end else begin
            r_form <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FIT_STRATEGY: r_fit_strategy <= i_cfg_data[0];
                    CFG_HEAP_BASE:    r_heap_base    <= i_cfg_data;
                    CFG_HEAP_UNITS: begin
                        r_heap_units <= i_cfg_data[12:0];
                        r_form       <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign cfg = '{fit_strategy: r_fit_strategy, heap_base: r_heap_base,
                   heap_units: r_heap_units, form: r_form};

    hba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    hba_hdr_mem #(
        .DEPTH(HEAP_UNITS),
        .WIDTH(HW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hba_ctrl #(
        .HEADER_UNITS (HEADER_UNITS),
        .HEAP_UNITS   (HEAP_UNITS),
        .IW           (IW),
        .HW           (HW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .i_div_done     (div_done),
        .i_div_quot     (div_quot),
        .i_div_rem      (div_rem),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );
endmodule

// ----- src/hba_hdr_mem.sv -----
// ----------------------------------------------------------------------------
// hba_hdr_mem
// Header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hba_hdr_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 29
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/hba_div.sv -----
// ----------------------------------------------------------------------------
// hba_div
// Granule scaler: splits a byte count into granules and a byte remainder.
// ----------------------------------------------------------------------------
module hba_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);
    import hba_pkg::*;

    logic [31:0] r_q;
    logic [31:0] r_rem;
    logic        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_q   <= i_dividend >> GRAN_SHIFT;
                r_rem <= i_dividend & 32'(GRANULE_BYTES - 1);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

// ----- src/hba_ctrl.sv -----
// ----------------------------------------------------------------------------
// hba_ctrl
// Request sequencer: walks and rewrites block headers in the header store.
// ----------------------------------------------------------------------------
module hba_ctrl #(
    parameter int HEADER_UNITS  = 1,
    parameter int HEAP_UNITS    = 4096,
    parameter int IW            = 12,
    parameter int HW            = 29
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hba_pkg::t_cfg         i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  hba_pkg::t_req         i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output hba_pkg::t_rsp         o_out_data,
    output logic                  o_div_start,
    output logic [31:0]           o_div_dividend,
    input  logic                  i_div_done,
    input  logic [31:0]           i_div_quot,
    input  logic [31:0]           i_div_rem,
    output logic                  o_mem_we,
    output logic [IW-1:0]         o_mem_waddr,
    output logic [HW-1:0]         o_mem_wdata,
    output logic                  o_mem_re,
    output logic [IW-1:0]         o_mem_raddr,
    input  logic [HW-1:0]         i_mem_rdata
);
    import hba_pkg::*;

    localparam int LW = $clog2(HEAP_UNITS + 1);
    localparam int XW = LW + 2;
    // header layout: len | prev | alloc | last | valid
    localparam int P_VALID = 0;
    localparam int P_LAST  = 1;
    localparam int P_ALLOC = 2;
    localparam int P_PREV  = 3;
    localparam int P_LEN   = 3 + LW;
    localparam logic [XW-1:0] X_HEAP = XW'(HEAP_UNITS);
    localparam logic [XW-1:0] X_HDR  = XW'(HEADER_UNITS);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DIV, S_ACHK, S_AW1, S_AW2, S_AW3,
        S_RG, S_RN, S_RPRE, S_RP, S_RPW, S_RSUCC, S_RSW, S_DONE
    } t_state;

    t_state        r_state, n_state;
    t_req          r_req, n_req;
    t_rsp          r_res, n_res;
    t_rsp          r_out;
    logic          r_out_valid;
    logic [IW-1:0] r_clr, n_clr;
    logic [XW-1:0] r_g, n_g;
    logic [IW-1:0] r_fit, n_fit;
    logic [HW-1:0] r_fit_hdr, n_fit_hdr;
    logic          r_found, n_found;
    logic [LW-1:0] r_need, n_need;
    logic [HW-1:0] r_b, n_b;
    logic [IW-1:0] r_cur, n_cur;
    logic [HW-1:0] r_cur_hdr, n_cur_hdr;
    logic [IW-1:0] r_n, n_n;
    logic [IW-1:0] r_s, n_s;
    logic          r_s_en, n_s_en;
    logic [LW-1:0] r_rem, n_rem;
    logic          r_old_last, n_old_last;

    logic [LW-1:0] units;
    logic [31:0]   units_raw;
    logic [HW-1:0] h;
    logic [XW-1:0] gn;
    logic [XW-1:0] xn;
    logic [XW-1:0] xs;
    logic          fits;
    logic          take;

    always_comb begin
        units_raw = 32'(i_cfg.heap_units);
        if (units_raw < 32'(HEADER_UNITS + 1)) begin
            units_raw = 32'(HEADER_UNITS + 1);
        end
        if (units_raw > 32'(HEAP_UNITS)) begin
            units_raw = 32'(HEAP_UNITS);
        end
        units = LW'(units_raw);
    end

    assign h    = i_mem_rdata;
    assign take = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_res      = r_res;
        n_clr      = r_clr;
        n_g        = r_g;
        n_fit      = r_fit;
        n_fit_hdr  = r_fit_hdr;
        n_found    = r_found;
        n_need     = r_need;
        n_b        = r_b;
        n_cur      = r_cur;
        n_cur_hdr  = r_cur_hdr;
        n_n        = r_n;
        n_s        = r_s;
        n_s_en     = r_s_en;
        n_rem      = r_rem;
        n_old_last = r_old_last;
        o_div_start    = 1'b0;
        o_div_dividend = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        gn   = '0;
        xn   = '0;
        xs   = '0;
        fits = 1'b0;

        case (r_state)
            S_CLR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                if (r_clr == '0) begin
                    o_mem_wdata[P_LEN +: LW] = units - LW'(HEADER_UNITS);
                    o_mem_wdata[P_LAST]      = 1'b1;
                    o_mem_wdata[P_VALID]     = 1'b1;
                end
                n_clr = r_clr + IW'(1);
                if (r_clr == IW'(HEAP_UNITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_data;
                    if (i_in_data.func == FUNC_RELEASE && i_in_data.release_addr == '0) begin
                        n_res   = '{block_addr: '0, status: ST_IGNORED};
                        n_state = S_DONE;
                    end else begin
                        o_div_start = 1'b1;
                        if (i_in_data.func == FUNC_ALLOC) begin
                            o_div_dividend = 32'(i_in_data.req_bytes)
                                             + 32'(GRANULE_BYTES - 1);
                        end else begin
                            o_div_dividend = i_in_data.release_addr - i_cfg.heap_base;
                        end
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_div_done) begin
                    if (r_req.func == FUNC_ALLOC) begin
                        n_need  = LW'(i_div_quot);
                        n_found = 1'b0;
                        n_g     = '0;
                        if (i_div_quot >= (32'(1) << LW)) begin
                            n_res   = '{block_addr: '0, status: ST_NO_FIT};
                            n_state = S_DONE;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = '0;
                            n_state     = S_ACHK;
                        end
                    end else begin
                        if (i_div_rem != '0 || i_div_quot < 32'(HEADER_UNITS)
                            || (i_div_quot - 32'(HEADER_UNITS)) >= 32'(units)) begin
                            n_res   = '{block_addr: '0, status: ST_IGNORED};
                            n_state = S_DONE;
                        end else begin
                            n_g         = XW'(i_div_quot - 32'(HEADER_UNITS));
                            o_mem_re    = 1'b1;
                            o_mem_raddr = IW'(i_div_quot - 32'(HEADER_UNITS));
                            n_state     = S_RG;
                        end
                    end
                end
            end
            // one header per cycle: the next read address comes from this one
            S_ACHK: begin
                fits = !h[P_ALLOC] && (h[P_LEN +: LW] >= r_need);
                gn   = r_g + X_HDR + XW'(h[P_LEN +: LW]);
                if (fits) begin
                    n_fit     = r_g[IW-1:0];
                    n_fit_hdr = h;
                    n_found   = 1'b1;
                end
                if ((fits && !i_cfg.fit_strategy) || h[P_LAST] || gn >= XW'(units)) begin
                    if (fits || r_found) begin
                        n_state = S_AW1;
                    end else begin
                        n_res   = '{block_addr: '0, status: ST_NO_FIT};
                        n_state = S_DONE;
                    end
                end else begin
                    n_g         = gn;
                    o_mem_re    = 1'b1;
                    o_mem_raddr = gn[IW-1:0];
                end
            end
            S_AW1: begin
                n_b        = r_fit_hdr;
                n_b[P_ALLOC] = 1'b1;
                n_old_last = r_fit_hdr[P_LAST];
                xn   = XW'(r_fit) + X_HDR + XW'(r_need);
                n_rem = r_fit_hdr[P_LEN +: LW] - r_need - LW'(HEADER_UNITS);
                xs   = xn + X_HDR + XW'(n_rem);
                n_n  = xn[IW-1:0];
                n_s  = xs[IW-1:0];
                n_res.block_addr = i_cfg.heap_base + (32'(r_fit) + 32'(HEADER_UNITS))
                                   * 32'(GRANULE_BYTES);
                n_res.status     = ST_ALLOCATED;
                n_state = S_DONE;
                if (XW'(r_fit_hdr[P_LEN +: LW]) >= XW'(r_need) + X_HDR + XW'(1)
                    && xn < X_HEAP) begin
                    n_b[P_LEN +: LW] = r_need;
                    n_b[P_LAST]      = 1'b0;
                    n_s_en = !r_fit_hdr[P_LAST] && xs < X_HEAP;
                    o_mem_re    = n_s_en;
                    o_mem_raddr = xs[IW-1:0];
                    n_state = S_AW2;
                end
                o_mem_we    = 1'b1;
                o_mem_waddr = r_fit;
                o_mem_wdata = n_b;
            end
            S_AW2: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_n;
                o_mem_wdata[P_LEN +: LW]  = r_rem;
                o_mem_wdata[P_PREV +: LW] = r_need;
                o_mem_wdata[P_LAST]       = r_old_last;
                o_mem_wdata[P_VALID]      = 1'b1;
                n_state = r_s_en ? S_AW3 : S_DONE;
            end
            S_AW3: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_s;
                o_mem_wdata = h;
                o_mem_wdata[P_PREV +: LW] = r_rem;
                n_state = S_DONE;
            end
            S_RG: begin
                if (!h[P_VALID]) begin
                    n_res   = '{block_addr: '0, status: ST_IGNORED};
                    n_state = S_DONE;
                end else begin
                    n_b = h;
                    n_b[P_ALLOC] = 1'b0;
                    xn  = r_g + X_HDR + XW'(h[P_LEN +: LW]);
                    n_n = xn[IW-1:0];
                    if (!h[P_LAST] && xn < X_HEAP) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = xn[IW-1:0];
                        n_state     = S_RN;
                    end else begin
                        n_state = S_RPRE;
                    end
                end
            end
            // forward merge: a free next header is retired
            S_RN: begin
                if (!h[P_ALLOC]) begin
                    n_b[P_LEN +: LW] = r_b[P_LEN +: LW] + LW'(HEADER_UNITS) + h[P_LEN +: LW];
                    if (h[P_LAST]) begin
                        n_b[P_LAST] = 1'b1;
                    end
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_n;
                    o_mem_wdata = h;
                    o_mem_wdata[P_VALID] = 1'b0;
                end
                n_state = S_RPRE;
            end
            S_RPRE: begin
                xn = X_HDR + XW'(r_b[P_PREV +: LW]);
                if (r_g != '0 && r_g >= xn) begin
                    xs          = r_g - xn;
                    n_cur       = xs[IW-1:0];
                    o_mem_re    = 1'b1;
                    o_mem_raddr = xs[IW-1:0];
                    n_state     = S_RP;
                end else begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_g[IW-1:0];
                    o_mem_wdata = r_b;
                    n_cur       = r_g[IW-1:0];
                    n_cur_hdr   = r_b;
                    n_state     = S_RSUCC;
                end
            end
            // backward merge into a free previous block
            S_RP: begin
                if (!h[P_ALLOC]) begin
                    n_cur_hdr = h;
                    n_cur_hdr[P_LEN +: LW] = h[P_LEN +: LW] + LW'(HEADER_UNITS)
                                             + r_b[P_LEN +: LW];
                    if (r_b[P_LAST]) begin
                        n_cur_hdr[P_LAST] = 1'b1;
                    end
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_cur;
                    o_mem_wdata = n_cur_hdr;
                    n_state     = S_RPW;
                end else begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_g[IW-1:0];
                    o_mem_wdata = r_b;
                    n_cur       = r_g[IW-1:0];
                    n_cur_hdr   = r_b;
                    n_state     = S_RSUCC;
                end
            end
            S_RPW: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_g[IW-1:0];
                o_mem_wdata = r_b;
                o_mem_wdata[P_VALID] = 1'b0;
                n_state = S_RSUCC;
            end
            S_RSUCC: begin
                xn  = XW'(r_cur) + X_HDR + XW'(r_cur_hdr[P_LEN +: LW]);
                n_n = xn[IW-1:0];
                n_res = '{block_addr: '0, status: ST_RELEASED};
                if (!r_cur_hdr[P_LAST] && xn < X_HEAP) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = xn[IW-1:0];
                    n_state     = S_RSW;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RSW: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_n;
                o_mem_wdata = h;
                o_mem_wdata[P_PREV +: LW] = r_cur_hdr[P_LEN +: LW];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg.form) begin
            n_clr   = '0;
            n_state = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (r_state == S_DONE && take) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_req      <= n_req;
        r_res      <= n_res;
        r_g        <= n_g;
        r_fit      <= n_fit;
        r_fit_hdr  <= n_fit_hdr;
        r_found    <= n_found;
        r_need     <= n_need;
        r_b        <= n_b;
        r_cur      <= n_cur;
        r_cur_hdr  <= n_cur_hdr;
        r_n        <= n_n;
        r_s        <= n_s;
        r_s_en     <= n_s_en;
        r_rem      <= n_rem;
        r_old_last <= n_old_last;
    end

    // a pending heap re-form takes the cycle, so no transfer is taken then
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg.form;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
